>>> hdl/ufs_pkg.sv
// Shared codes and constants for the URI field splitter.
`default_nettype none
package ufs_pkg;

    // Parser phases.
    localparam logic [3:0] PH_SCHEME = 4'd0;
    localparam logic [3:0] PH_COLON  = 4'd1;
    localparam logic [3:0] PH_SLASH  = 4'd2;
    localparam logic [3:0] PH_PATH   = 4'd3;
    localparam logic [3:0] PH_QLIST  = 4'd4;
    localparam logic [3:0] PH_KEY    = 4'd5;
    localparam logic [3:0] PH_VALUE  = 4'd6;
    localparam logic [3:0] PH_FRAG   = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;

    // Byte roles.
    typedef logic [3:0] role_t;
    localparam role_t ROLE_SCHEME = 4'd0;
    localparam role_t ROLE_SDELIM = 4'd1;
    localparam role_t ROLE_PATH   = 4'd2;
    localparam role_t ROLE_QDELIM = 4'd3;
    localparam role_t ROLE_KEY    = 4'd4;
    localparam role_t ROLE_VALUE  = 4'd5;
    localparam role_t ROLE_HASH   = 4'd6;
    localparam role_t ROLE_FRAG   = 4'd7;
    localparam role_t ROLE_IGN    = 4'd8;

    // Scheme verdict codes.
    typedef logic [1:0] verdict_t;
    localparam verdict_t SRC_UNDECIDED = 2'd0;
    localparam verdict_t SRC_INPUT     = 2'd1;
    localparam verdict_t SRC_DEFAULT   = 2'd2;

    // Status codes.
    typedef logic [2:0] status_t;
    localparam status_t ST_RUNNING   = 3'd0;
    localparam status_t ST_SUCCESS   = 3'd1;
    localparam status_t ST_NO_SCHEME = 3'd2;
    localparam status_t ST_QUERY_OFF = 3'd3;
    localparam status_t ST_FRAG_OFF  = 3'd4;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_HAS_DEFAULT = 2'd0;
    localparam cfg_index_t REG_QUERIES_EN  = 2'd1;
    localparam cfg_index_t REG_FRAGS_EN    = 2'd2;

    // Delimiter bytes.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result tdata layout: char_out, param_index, scheme_source, status.
    localparam int TD_CHAR_LSB   = 0;
    localparam int TD_INDEX_LSB  = 8;
    localparam int TD_SOURCE_LSB = 16;
    localparam int TD_STATUS_LSB = 18;
    localparam int TD_WIDTH      = 24;

endpackage
`default_nettype wire

>>> hdl/uri_field_splitter.sv
// Top level of the URI field splitter: phase machine and result register.
`default_nettype none
// The block takes a URI one byte per item on the s_ side and returns one
// result item per byte on the m_ side: the byte itself, its role (scheme,
// scheme delimiter, path, query delimiter, key, value, hash, fragment or
// ignored), the index of the current query parameter as it stood before the
// byte (capped at 255), the scheme verdict and the status. The item marked by
// s_tlast closes the URI; its result carries the final status and the parser
// then returns to the scheme phase, keeping the configuration. Throughput is
// one item per clock cycle while the m_ side takes results: the phase machine
// decides each byte combinationally and writes the result register, and
// s_tready is high whenever that register is empty or is being taken in the
// same cycle. Configuration writes are taken at any time (cfg_ready is always
// high) but should be made only while no URI is in flight. The parameter
// INDEX_BITS sets the width of the internal query parameter counter, which
// saturates at its all-ones value.
module uri_field_splitter #(
    parameter int INDEX_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input items.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] char_in
    input  wire logic                 s_tlast,   // last_char
    // Result items.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // [7:0] char_out, [15:8] param_index,
                                                 // [17:16] scheme_source, [20:18] status,
                                                 // [23:21] zero
    output ufs_pkg::role_t            m_tuser,   // [3:0] role
    output logic                      m_tlast,   // last_out
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire ufs_pkg::cfg_index_t  cfg_index,
    input  wire logic                 cfg_data
);
    import ufs_pkg::*;

    // Configuration registers.
    logic has_default_reg;
    logic queries_en_reg;
    logic frags_en_reg;

    // Parser state.
    logic [3:0]            phase_reg,    phase_next;
    logic                  nonempty_reg, nonempty_next;
    logic [INDEX_BITS-1:0] count_reg,    count_next;
    verdict_t              verdict_reg,  verdict_next;
    status_t               status_reg,   status_next;

    // Result register.
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    role_t                 out_role_reg;
    logic [7:0]            out_index_reg;
    verdict_t              out_source_reg;
    status_t               out_status_reg;
    logic                  out_last_reg;

    // Per-byte decision.
    logic [7:0]            c;
    logic                  accept;
    role_t                 role;
    logic [3:0]            ph;
    logic                  ne;
    verdict_t              ver;
    status_t               st;
    logic                  do_path, do_key, do_hash, do_ok, bump;
    logic [16:0]           count_wide;
    logic [7:0]            index_cap;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign c         = s_tdata;

    // The parameter index reported is the counter before this byte, capped at 255.
    assign count_wide = 17'(count_reg);
    assign index_cap  = (count_wide > 17'd255) ? 8'hFF : count_wide[7:0];

    always_comb begin
        ph      = phase_reg;
        ne      = nonempty_reg;
        ver     = verdict_reg;
        st      = status_reg;
        role    = ROLE_IGN;
        do_path = 1'b0;
        do_key  = 1'b0;
        do_hash = 1'b0;
        do_ok   = 1'b0;
        bump    = 1'b0;

        unique case (phase_reg)
            PH_SCHEME: begin
                if (c == CH_COLON) begin
                    role = ROLE_SDELIM;
                    ph   = PH_COLON;
                end else begin
                    role = ROLE_SCHEME;
                    ne   = 1'b1;
                end
            end
            PH_COLON: begin
                if (c == CH_SLASH) begin
                    role = ROLE_SDELIM;
                    ph   = PH_SLASH;
                end else if (nonempty_reg) begin
                    ver     = SRC_INPUT;
                    do_path = 1'b1;
                end else if (has_default_reg) begin
                    ver     = SRC_DEFAULT;
                    do_path = 1'b1;
                end else begin
                    st = ST_NO_SCHEME;
                    ph = PH_DONE;
                end
            end
            PH_SLASH: begin
                if (c == CH_SLASH) begin
                    // The double slash is whole; the role stays a delimiter
                    // even when the scheme then fails.
                    role = ROLE_SDELIM;
                    if (nonempty_reg) begin
                        ver = SRC_INPUT;
                        ph  = PH_PATH;
                    end else if (has_default_reg) begin
                        ver = SRC_DEFAULT;
                        ph  = PH_PATH;
                    end else begin
                        st = ST_NO_SCHEME;
                        ph = PH_DONE;
                    end
                end else if (has_default_reg) begin
                    // A broken delimiter: the default scheme takes over and
                    // this byte starts the path.
                    ver     = SRC_DEFAULT;
                    do_path = 1'b1;
                end else begin
                    st = ST_NO_SCHEME;
                    ph = PH_DONE;
                end
            end
            PH_PATH: begin
                do_path = 1'b1;
            end
            PH_QLIST: begin
                if (c == CH_HASH) begin
                    do_hash = 1'b1;
                end else if (c == CH_NUL) begin
                    do_ok = 1'b1;
                end else begin
                    do_key = 1'b1;
                end
            end
            PH_KEY: begin
                do_key = 1'b1;
            end
            PH_VALUE: begin
                if (c == CH_AMP) begin
                    bump = 1'b1;
                    ph   = PH_QLIST;
                    role = ROLE_QDELIM;
                end else if (c == CH_HASH) begin
                    bump    = 1'b1;
                    do_hash = 1'b1;
                end else if (c == CH_NUL) begin
                    bump  = 1'b1;
                    do_ok = 1'b1;
                end else begin
                    role = ROLE_VALUE;
                end
            end
            PH_FRAG: begin
                if (c == CH_NUL) begin
                    do_ok = 1'b1;
                end else begin
                    role = ROLE_FRAG;
                end
            end
            default: begin
                ph = PH_DONE;
            end
        endcase

        // Path text, or the delimiter that ends the path.
        if (do_path) begin
            if (c == CH_QUEST) begin
                if (!queries_en_reg) begin
                    st   = ST_QUERY_OFF;
                    ph   = PH_DONE;
                    role = ROLE_IGN;
                end else begin
                    ph   = PH_QLIST;
                    role = ROLE_QDELIM;
                end
            end else if (c == CH_HASH) begin
                do_hash = 1'b1;
            end else begin
                ph   = PH_PATH;
                role = ROLE_PATH;
            end
        end

        // Key text, or the delimiter that ends the key.
        if (do_key) begin
            if (c == CH_EQUAL) begin
                ph   = PH_VALUE;
                role = ROLE_QDELIM;
            end else if (c == CH_AMP) begin
                bump = 1'b1;
                ph   = PH_QLIST;
                role = ROLE_QDELIM;
            end else if (c == CH_HASH) begin
                bump    = 1'b1;
                do_hash = 1'b1;
            end else if (c == CH_NUL) begin
                bump  = 1'b1;
                do_ok = 1'b1;
            end else begin
                ph   = PH_KEY;
                role = ROLE_KEY;
            end
        end

        // A hash opens the fragment, or fails when fragments are off.
        if (do_hash) begin
            if (!frags_en_reg) begin
                st   = ST_FRAG_OFF;
                ph   = PH_DONE;
                role = ROLE_IGN;
            end else begin
                ph   = PH_FRAG;
                role = ROLE_HASH;
            end
        end

        // A NUL in the query or fragment ends the URI with success.
        if (do_ok) begin
            st   = ST_SUCCESS;
            ph   = PH_DONE;
            role = ROLE_IGN;
        end

        // End of stream after the last byte.
        if (s_tlast) begin
            unique case (ph)
                PH_SCHEME, PH_SLASH: begin
                    if (has_default_reg) begin
                        ver = SRC_DEFAULT;
                        st  = ST_SUCCESS;
                    end else begin
                        st = ST_NO_SCHEME;
                    end
                    ph = PH_DONE;
                end
                PH_COLON: begin
                    if (ne) begin
                        ver = SRC_INPUT;
                        st  = ST_SUCCESS;
                    end else if (has_default_reg) begin
                        ver = SRC_DEFAULT;
                        st  = ST_SUCCESS;
                    end else begin
                        st = ST_NO_SCHEME;
                    end
                    ph = PH_DONE;
                end
                PH_PATH, PH_QLIST, PH_FRAG: begin
                    st = ST_SUCCESS;
                    ph = PH_DONE;
                end
                PH_KEY, PH_VALUE: begin
                    // An open parameter is closed and counted.
                    bump = 1'b1;
                    st   = ST_SUCCESS;
                    ph   = PH_DONE;
                end
                default: begin
                    ph = PH_DONE;
                end
            endcase
        end

        phase_next    = ph;
        nonempty_next = ne;
        verdict_next  = ver;
        status_next   = st;
        if (bump && (count_reg != {INDEX_BITS{1'b1}})) begin
            count_next = count_reg + INDEX_BITS'(1);
        end else begin
            count_next = count_reg;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_default_reg <= 1'b0;
            queries_en_reg  <= 1'b1;
            frags_en_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HAS_DEFAULT: has_default_reg <= cfg_data;
                REG_QUERIES_EN:  queries_en_reg  <= cfg_data;
                REG_FRAGS_EN:    frags_en_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parser state; the last byte sends it back to the start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SCHEME;
            nonempty_reg <= 1'b0;
            count_reg    <= '0;
            verdict_reg  <= SRC_UNDECIDED;
            status_reg   <= ST_RUNNING;
        end else if (accept) begin
            if (s_tlast) begin
                phase_reg    <= PH_SCHEME;
                nonempty_reg <= 1'b0;
                count_reg    <= '0;
                verdict_reg  <= SRC_UNDECIDED;
                status_reg   <= ST_RUNNING;
            end else begin
                phase_reg    <= phase_next;
                nonempty_reg <= nonempty_next;
                count_reg    <= count_next;
                verdict_reg  <= verdict_next;
                status_reg   <= status_next;
            end
        end
    end

    // Result register: valid bit under reset, payload loaded on accept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_char_reg   <= c;
            out_role_reg   <= role;
            out_index_reg  <= index_cap;
            out_source_reg <= verdict_next;
            out_status_reg <= status_next;
            out_last_reg   <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_source_reg, out_index_reg, out_char_reg};
    assign m_tuser  = out_role_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> hdl/ufs_checker.sv
// Port-level assertions for the URI field splitter and their bind.
`default_nettype none
module ufs_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_tready,
    input wire logic           m_tvalid,
    input wire logic           m_tready,
    input wire logic [23:0]    m_tdata,
    input wire ufs_pkg::role_t m_tuser,
    input wire logic           m_tlast
);
    import ufs_pkg::*;

    verdict_t src;
    status_t  st;

    assign src = m_tdata[TD_SOURCE_LSB +: 2];
    assign st  = m_tdata[TD_STATUS_LSB +: 3];

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // A full, stalled output must hold off new input items.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted over a stalled result");

    // The final item of a URI always reports a final status.
    a_final_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> st != ST_RUNNING)
        else $error("last item reported running status");

    // After a disabled query or fragment every byte is ignored.
    a_disabled_ign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_QUERY_OFF || st == ST_FRAG_OFF) |-> m_tuser == ROLE_IGN)
        else $error("byte classified after a disabled part");

    // Any byte past the scheme needs a decided scheme; a scheme error leaves none.
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser != ROLE_SCHEME && m_tuser != ROLE_SDELIM
                      && m_tuser != ROLE_IGN) || st == ST_NO_SCHEME)
        |-> ((st == ST_NO_SCHEME) == (src == SRC_UNDECIDED)))
        else $error("scheme verdict inconsistent with role or status");

endmodule

bind uri_field_splitter ufs_checker u_ufs_checker (.*);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the URI field splitter.
module tb;
    import ufs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 105;
    localparam int SAT_AMPS    = 300;
    // Index 3 maps to no register; writes to it must be ignored.
    localparam cfg_index_t REG_UNUSED = 2'd3;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_TOP     = 8'hFF;

    typedef struct packed {
        logic [7:0] ch;
        role_t      role;
        logic [7:0] idx;
        verdict_t   src;
        status_t    st;
        logic       is_last;
    } byte_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;
    role_t            m_tuser;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_index_t       cfg_index = REG_HAS_DEFAULT;
    logic             cfg_data = 1'b0;

    uri_field_splitter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Parser state as the classifier tracks it.
    logic [3:0]  ph = PH_SCHEME;
    logic        scheme_seen = 1'b0;
    logic [7:0]  nparams = '0;
    verdict_t    verdict = SRC_UNDECIDED;
    status_t     stat = ST_RUNNING;
    logic        use_default = 1'b0;
    logic        queries_on = 1'b1;
    logic        frags_on = 1'b1;

    byte_result_t classified_q[$];
    logic [7:0]   uri_buf[$];

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_uris = 0;
    int cycle_count = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int stall_left = 0;

    // ---------------------------------------------------------------- classifier
    function void clear_parse();
        ph = PH_SCHEME;
        scheme_seen = 1'b0;
        nparams = '0;
        verdict = SRC_UNDECIDED;
        stat = ST_RUNNING;
    endfunction

    function void bump_params();
        if (nparams != 8'hFF) nparams++;
    endfunction

    function bit settle_scheme(input bit from_input);
        if (from_input) begin
            verdict = SRC_INPUT;
            return 1'b1;
        end
        if (use_default) begin
            verdict = SRC_DEFAULT;
            return 1'b1;
        end
        stat = ST_NO_SCHEME;
        ph = PH_DONE;
        return 1'b0;
    endfunction

    function void close_ok();
        stat = ST_SUCCESS;
        ph = PH_DONE;
    endfunction

    function role_t hash_role();
        if (!frags_on) begin
            stat = ST_FRAG_OFF;
            ph = PH_DONE;
            return ROLE_IGN;
        end
        ph = PH_FRAG;
        return ROLE_HASH;
    endfunction

    function role_t path_role(input logic [7:0] c);
        if (c == CH_QUEST) begin
            if (!queries_on) begin
                stat = ST_QUERY_OFF;
                ph = PH_DONE;
                return ROLE_IGN;
            end
            ph = PH_QLIST;
            return ROLE_QDELIM;
        end
        if (c == CH_HASH) return hash_role();
        ph = PH_PATH;
        return ROLE_PATH;
    endfunction

    function role_t key_role(input logic [7:0] c);
        if (c == CH_EQUAL) begin
            ph = PH_VALUE;
            return ROLE_QDELIM;
        end
        if (c == CH_AMP) begin
            bump_params();
            ph = PH_QLIST;
            return ROLE_QDELIM;
        end
        if (c == CH_HASH) begin
            bump_params();
            return hash_role();
        end
        if (c == CH_NUL) begin
            bump_params();
            close_ok();
            return ROLE_IGN;
        end
        ph = PH_KEY;
        return ROLE_KEY;
    endfunction

    // Works out the result for one byte and advances the parser state.
    function byte_result_t classify_byte(input logic [7:0] c, input logic is_last);
        byte_result_t r;
        role_t        role;
        r.idx = nparams;
        role = ROLE_IGN;
        case (ph)
            PH_SCHEME: begin
                if (c == CH_COLON) begin
                    role = ROLE_SDELIM;
                    ph = PH_COLON;
                end else begin
                    role = ROLE_SCHEME;
                    scheme_seen = 1'b1;
                end
            end
            PH_COLON: begin
                if (c == CH_SLASH) begin
                    role = ROLE_SDELIM;
                    ph = PH_SLASH;
                end else if (settle_scheme(scheme_seen)) begin
                    role = path_role(c);
                end
            end
            PH_SLASH: begin
                if (c == CH_SLASH) begin
                    role = ROLE_SDELIM;
                    if (settle_scheme(scheme_seen)) ph = PH_PATH;
                end else if (settle_scheme(1'b0)) begin
                    role = path_role(c);
                end
            end
            PH_PATH: role = path_role(c);
            PH_QLIST: begin
                if (c == CH_HASH) role = hash_role();
                else if (c == CH_NUL) close_ok();
                else role = key_role(c);
            end
            PH_KEY: role = key_role(c);
            PH_VALUE: begin
                if (c == CH_AMP) begin
                    bump_params();
                    ph = PH_QLIST;
                    role = ROLE_QDELIM;
                end else if (c == CH_HASH) begin
                    bump_params();
                    role = hash_role();
                end else if (c == CH_NUL) begin
                    bump_params();
                    close_ok();
                end else begin
                    role = ROLE_VALUE;
                end
            end
            PH_FRAG: begin
                if (c == CH_NUL) close_ok();
                else role = ROLE_FRAG;
            end
            default: ph = PH_DONE;
        endcase

        // End of stream closes whatever is still open.
        if (is_last) begin
            case (ph)
                PH_SCHEME, PH_SLASH: if (settle_scheme(1'b0)) close_ok();
                PH_COLON: if (settle_scheme(scheme_seen)) close_ok();
                PH_PATH, PH_QLIST, PH_FRAG: close_ok();
                PH_KEY, PH_VALUE: begin
                    bump_params();
                    close_ok();
                end
                default: ;
            endcase
        end

        r.ch = c;
        r.role = role;
        r.src = verdict;
        r.st = stat;
        r.is_last = is_last;
        if (is_last) clear_parse();
        return r;
    endfunction

    // ---------------------------------------------------------------- result side
    // Receiver stalls: mostly short, occasionally long, none when the rate is zero.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            m_tready <= 1'b0;
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                   : $urandom_range(2, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        byte_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (classified_q.size() == 0) begin
                $error("result item 0x%06h arrived with nothing predicted", m_tdata);
                n_errors++;
            end else begin
                want = classified_q.pop_front();
                check_field("char_out", want.ch, m_tdata[TD_INDEX_LSB-1:TD_CHAR_LSB]);
                check_field("role", want.role, m_tuser);
                check_field("param_index", want.idx, m_tdata[TD_SOURCE_LSB-1:TD_INDEX_LSB]);
                check_field("scheme_source", want.src,
                            m_tdata[TD_STATUS_LSB-1:TD_SOURCE_LSB]);
                check_field("status", want.st, m_tdata[TD_STATUS_LSB+2:TD_STATUS_LSB]);
                check_field("tdata_pad", 0, m_tdata[TD_WIDTH-1:TD_STATUS_LSB+3]);
                check_field("last_out", want.is_last, m_tlast);
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, classified_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- input side
    function int pick_gap();
        if ($urandom_range(99) >= tx_gap_pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    // Sends one byte; tvalid stays high afterwards so back-to-back bytes
    // need no extra assignment in the acceptance step.
    task send_byte(input logic [7:0] c, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= is_last;
        do @(posedge aclk); while (!s_tready);
        classified_q.push_back(classify_byte(c, is_last));
        n_sent++;
    endtask

    task send_uri();
        int i;
        for (i = 0; i < uri_buf.size(); i++)
            send_byte(uri_buf[i], i == uri_buf.size() - 1);
        n_uris++;
        uri_buf.delete();
    endtask

    // Holds the sender until every predicted result has come back.
    task drain();
        s_tvalid <= 1'b0;
        while (classified_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task write_reg(input cfg_index_t idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_HAS_DEFAULT: use_default = val;
            REG_QUERIES_EN:  queries_on = val;
            REG_FRAGS_EN:    frags_on = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task set_config(input logic dflt, input logic qen, input logic fen);
        drain();
        write_reg(REG_HAS_DEFAULT, dflt);
        write_reg(REG_QUERIES_EN, qen);
        write_reg(REG_FRAGS_EN, fen);
    endtask

    function void put_str(input string s);
        for (int i = 0; i < s.len(); i++) uri_buf.push_back(s[i]);
    endfunction

    // Mostly letters, now and then any byte at all.
    function logic [7:0] text_byte();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return CH_LOWER_A + 8'($urandom_range(25));
    endfunction

    // Builds one URI: mostly well formed with random content, some pure noise,
    // some with broken scheme delimiters or cut short.
    function void make_uri();
        int n;
        int k;
        int p;
        uri_buf.delete();
        if ($urandom_range(99) < 12) begin
            n = $urandom_range(12, 1);
            repeat (n) uri_buf.push_back(8'($urandom_range(255)));
            return;
        end
        n = $urandom_range(5, 0);
        repeat (n) uri_buf.push_back(text_byte());
        k = $urandom_range(9);
        if (k < 7) put_str("://");
        else if (k == 7) put_str(":");
        else if (k == 8) put_str(":/");
        n = $urandom_range(6, 0);
        repeat (n) uri_buf.push_back(($urandom_range(4) == 0) ? CH_SLASH : text_byte());
        if ($urandom_range(1) == 1) begin
            uri_buf.push_back(CH_QUEST);
            p = $urandom_range(4, 0);
            for (k = 0; k < p; k++) begin
                if (k != 0) uri_buf.push_back(CH_AMP);
                n = $urandom_range(3, 0);
                repeat (n) uri_buf.push_back(($urandom_range(7) == 0) ? CH_QUEST : text_byte());
                if ($urandom_range(2) != 0) begin
                    uri_buf.push_back(CH_EQUAL);
                    n = $urandom_range(3, 0);
                    repeat (n) uri_buf.push_back(text_byte());
                end
            end
        end
        if ($urandom_range(9) < 3) begin
            uri_buf.push_back(CH_HASH);
            n = $urandom_range(4, 0);
            repeat (n) uri_buf.push_back(text_byte());
        end
        if ($urandom_range(9) < 2) begin
            uri_buf.push_back(CH_NUL);
            n = $urandom_range(3, 0);
            repeat (n) uri_buf.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(9) == 0 && uri_buf.size() > 1) begin
            n = $urandom_range(uri_buf.size() - 1, 1);
            while (uri_buf.size() > n) void'(uri_buf.pop_back());
        end
        if (uri_buf.size() == 0) uri_buf.push_back(text_byte());
    endfunction

    // ---------------------------------------------------------------- tests
    // Every role but the ignored one in one URI, including an empty parameter opened by '='.
    task test_all_roles();
        put_str("h://p?k=v&=#f");
        send_uri();
    endtask

    // Scheme delimiter variants with and without a default scheme.
    task test_scheme_cases();
        put_str("a:b");
        send_uri();
        put_str(":x");
        send_uri();
        put_str("ab");
        send_uri();
        set_config(1'b1, 1'b1, 1'b1);
        put_str(":/x");
        send_uri();
        put_str("ab");
        send_uri();
        // A NUL inside the scheme and the path is plain text.
        uri_buf.push_back(CH_NUL);
        put_str("://");
        uri_buf.push_back(CH_NUL);
        send_uri();
    endtask

    // Query and fragment parts that are switched off; the unused index is poked too.
    task test_disabled_parts();
        set_config(1'b0, 1'b0, 1'b1);
        write_reg(REG_UNUSED, 1'b1);
        put_str("s:p?q");
        send_uri();
        set_config(1'b0, 1'b1, 1'b0);
        put_str("s:p#f");
        send_uri();
    endtask

    // A stray '?' in a key, then a NUL that ends the query; later bytes are ignored.
    task test_query_termination();
        set_config(1'b0, 1'b1, 1'b1);
        put_str("s:?k?x=v");
        uri_buf.push_back(CH_NUL);
        uri_buf.push_back(CH_TOP);
        send_uri();
    endtask

    // Enough empty parameters to saturate the index.
    task test_param_saturation();
        put_str("s:?");
        repeat (SAT_AMPS) uri_buf.push_back(CH_AMP);
        put_str("k");
        send_uri();
    endtask

    // Random URIs under all eight register settings with varying idle rates.
    task test_random_settings();
        logic [2:0] combo;
        int         sent_here;
        bit         paused;
        for (int s = 0; s < 8; s++) begin
            combo = 3'(s);
            set_config(combo[0], combo[1], combo[2]);
            case (s % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 20; rx_stall_pct = 20; end
                2: begin tx_gap_pct = 60; rx_stall_pct = 10; end
                default: begin tx_gap_pct = 10; rx_stall_pct = 60; end
            endcase
            sent_here = 0;
            paused = 1'b0;
            while (sent_here < PHASE_BYTES) begin
                make_uri();
                sent_here += uri_buf.size();
                send_uri();
                if (!paused && sent_here > PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_gap_pct = 25;
        rx_stall_pct = 25;
        test_all_roles();
        test_scheme_cases();
        test_disabled_parts();
        test_query_termination();
        test_param_saturation();
        test_random_settings();

        drain();
        repeat (5) @(posedge aclk);
        $display("Sent %0d bytes in %0d URIs over all register settings, checked %0d results.",
                 n_sent, n_uris, n_checked);
        $display("Runs included directed delimiter cases, index saturation and idle gaps.");
        if (n_errors == 0 && classified_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
